// ===== design/chd_pkg.sv =====
`default_nettype none

package chd_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_COUNT = 256;

  // code_length never reaches MAX_CODE_LEN in the register: a full-length miss returns to root
  localparam int CL_W  = 4;
  localparam int IDX_W = 8;
  localparam int VAL_W = 8;
  localparam int FC_W  = 17;
  localparam int FI_W  = 9;

  localparam logic [FC_W-1:0] FIRST_CODE_MAX  = 17'h1FFFF;
  localparam logic [FI_W-1:0] FIRST_INDEX_MAX = 9'd511;

  typedef enum logic [1:0] {
    CMD_LOAD_COUNT  = 2'd0,
    CMD_LOAD_SYMBOL = 2'd1,
    CMD_BIT         = 2'd2,
    CMD_END         = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SYMBOL    = 2'd0,
    ST_END_CLEAN = 2'd1,
    ST_END_TRUNC = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== design/canonical_huffman_decoder.sv =====
`default_nettype none

// Canonical Huffman decoder with JPEG DHT style tables.
// Input channel s_*: s_tuser carries the command. Load commands write the
// sixteen length counts and the symbol table and return the decoder to the
// root without a result. A coded-bit command walks one bit; an end command
// reports a clean end or a truncated code.
// Output channel m_*: one item per completed code, per end command and per
// invalid bit string; m_tuser is the status, m_tdata the symbol.
// Throughput: one input item per cycle while s_tready is high. The length
// count for the next bit is read from its memory ahead of that bit, addressed
// by the next code length. A result passes through the pending stage, which
// holds the registered read of the symbol memory, then the output register.
// Reset clears the decoder to the root and empties the result pipeline; the
// tables are not cleared and must be loaded before decoding.
// When the receiver stalls, one further result-bearing item is taken into
// the pending stage, then s_tready drops until the output register drains.
module canonical_huffman_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // table_index[7:0], table_value[15:8], coded_bit[16]
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // symbol[7:0]
  output logic      [1:0]  m_tuser    // status[1:0]
);

  import chd_pkg::*;

  logic             in_acc;
  cmd_t             cmd;
  logic [IDX_W-1:0] table_index;
  logic [VAL_W-1:0] table_value;
  logic             coded_bit;

  // decoder state
  logic [MAX_CODE_LEN-2:0] partial_code, partial_code_next;
  logic [CL_W-1:0]         code_length, code_length_next;
  logic [FC_W-1:0]         first_code, first_code_next;
  logic [FI_W-1:0]         first_index, first_index_next;

  // length count memory and forwarding of a same-address write
  logic             cnt_we;
  logic [VAL_W-1:0] cnt_rdata;
  logic             fwd_valid;
  logic [VAL_W-1:0] fwd_data;
  logic [VAL_W-1:0] count;

  // symbol memory
  logic             sym_we;
  logic             sym_re;
  logic [IDX_W-1:0] sym_raddr;
  logic [VAL_W-1:0] sym_rdata;

  // per-bit arithmetic
  logic [MAX_CODE_LEN-1:0] pc_new;
  logic [CL_W:0]           cl_new;
  logic [FC_W:0]           code_diff;
  logic                    hit;
  logic [FI_W:0]           pos;
  logic [FI_W:0]           fi_sum;
  logic [FC_W:0]           fc_sum;

  // result pipeline
  logic    res_load;
  status_t res_status;
  logic    res_is_sym;
  logic    p_valid, p_is_sym, p_adv;
  status_t p_status;
  logic    o_valid;
  status_t o_status;
  logic [VAL_W-1:0] o_symbol;

  assign cmd         = cmd_t'(s_tuser);
  assign table_index = s_tdata[7:0];
  assign table_value = s_tdata[15:8];
  assign coded_bit   = s_tdata[16];

  assign p_adv    = !o_valid || m_tready;
  assign s_tready = !p_valid || p_adv;
  assign in_acc   = s_tvalid && s_tready;

  assign count = fwd_valid ? fwd_data : cnt_rdata;

  assign pc_new    = {partial_code, coded_bit};
  assign cl_new    = {1'b0, code_length} + 5'd1;
  assign code_diff = {2'b00, pc_new} - {1'b0, first_code};
  assign hit       = !code_diff[FC_W] && (code_diff[FC_W-1:0] < {9'd0, count});
  assign pos       = {1'b0, first_index} + {2'b00, code_diff[7:0]};
  assign fi_sum    = {1'b0, first_index} + {2'b00, count};
  assign fc_sum    = {1'b0, first_code} + {10'd0, count};
  assign sym_raddr = pos[IDX_W-1:0];

  always_comb begin
    partial_code_next = partial_code;
    code_length_next  = code_length;
    first_code_next   = first_code;
    first_index_next  = first_index;
    cnt_we            = 1'b0;
    sym_we            = 1'b0;
    sym_re            = 1'b0;
    res_load          = 1'b0;
    res_status        = ST_SYMBOL;
    res_is_sym        = 1'b0;
    if (in_acc) begin
      unique case (cmd)
        CMD_LOAD_COUNT: begin
          cnt_we            = table_index < IDX_W'(MAX_CODE_LEN);
          partial_code_next = '0;
          code_length_next  = '0;
          first_code_next   = '0;
          first_index_next  = '0;
        end
        CMD_LOAD_SYMBOL: begin
          sym_we            = {1'b0, table_index} < (IDX_W+1)'(SYMBOL_COUNT);
          partial_code_next = '0;
          code_length_next  = '0;
          first_code_next   = '0;
          first_index_next  = '0;
        end
        CMD_END: begin
          res_load          = 1'b1;
          res_status        = (code_length == '0) ? ST_END_CLEAN : ST_END_TRUNC;
          partial_code_next = '0;
          code_length_next  = '0;
          first_code_next   = '0;
          first_index_next  = '0;
        end
        CMD_BIT: begin
          if (hit) begin
            res_load          = 1'b1;
            partial_code_next = '0;
            code_length_next  = '0;
            first_code_next   = '0;
            first_index_next  = '0;
            if (pos >= (FI_W+1)'(SYMBOL_COUNT)) begin
              res_status = ST_INVALID;
            end else begin
              sym_re     = 1'b1;
              res_is_sym = 1'b1;
            end
          end else if (cl_new >= (CL_W+1)'(MAX_CODE_LEN)) begin
            // no code within the longest length: report and restart
            res_load          = 1'b1;
            res_status        = ST_INVALID;
            partial_code_next = '0;
            code_length_next  = '0;
            first_code_next   = '0;
            first_index_next  = '0;
          end else begin
            partial_code_next = pc_new[MAX_CODE_LEN-2:0];
            code_length_next  = cl_new[CL_W-1:0];
            first_index_next  = (fi_sum > {1'b0, FIRST_INDEX_MAX}) ? FIRST_INDEX_MAX
                                                                  : fi_sum[FI_W-1:0];
            first_code_next   = (fc_sum > 18'h0FFFF) ? FIRST_CODE_MAX
                                                     : {fc_sum[FC_W-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  // count for the next bit is fetched with the next code length as address
  chd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_CODE_LEN)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (table_index[CL_W-1:0]),
    .wdata (table_value),
    .re    (1'b1),
    .raddr (code_length_next),
    .rdata (cnt_rdata)
  );

  chd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_symbol_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (table_index),
    .wdata (table_value),
    .re    (sym_re),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      code_length  <= '0;
      first_code   <= '0;
      first_index  <= '0;
      fwd_valid    <= 1'b0;
      p_valid      <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      partial_code <= partial_code_next;
      code_length  <= code_length_next;
      first_code   <= first_code_next;
      first_index  <= first_index_next;
      // the memory returns old data on a same-address write: forward it
      fwd_valid    <= cnt_we && (table_index[CL_W-1:0] == code_length_next);
      p_valid      <= (p_valid && !p_adv) || res_load;
      if (p_adv) begin
        o_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= table_value;
    if (res_load) begin
      p_status <= res_status;
      p_is_sym <= res_is_sym;
    end
    if (p_valid && p_adv) begin
      o_status <= p_status;
      o_symbol <= p_is_sym ? sym_rdata : '0;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_symbol;
  assign m_tuser  = o_status;

  // received bits never reach above the current code length
  a_partial_fits: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, partial_code} >> code_length) == '0))
    else $error("partial code wider than code length");

  a_root_clean: assert property (@(posedge clk) disable iff (rst)
    (code_length == '0) |-> (first_code == '0 && first_index == '0))
    else $error("canonical walk state not cleared at root");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (p_valid && o_valid))
    else $error("input held off with room in the result pipeline");

  a_sym_read_pending: assert property (@(posedge clk) disable iff (rst)
    sym_re |=> (p_valid && p_is_sym))
    else $error("symbol read issued without a pending result");

  a_pending_holds: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !p_adv) |=> (p_valid && $stable(p_status)))
    else $error("pending result lost under stall");

endmodule

`default_nettype wire

// ===== design/chd_ram.sv =====
`default_nettype none

module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
